// File: design/vno_pkg.sv
// ----------------------------------------------------------------------------
// vno_pkg: shared types, constants and helpers of the vector arithmetic unit
// Fixed-point format, command codes, the sideband record that travels along
// the pipeline, and the rounding and saturation helpers.
// ----------------------------------------------------------------------------
package vno_pkg;

	localparam int FRAC_BITS = 16;
	// Square root steps: one result bit per stage for a 64-bit radicand.
	localparam int SQ_STEPS = 32;
	// Normalized magnitudes stay below 2^(FRAC_BITS+2).
	localparam int QW = FRAC_BITS + 2;
	// Dividend width: |c| << FRAC_BITS plus half the divisor.
	localparam int DW = FRAC_BITS + 33;

	typedef enum logic [2:0] {
		CMD_ADD   = 3'd0,
		CMD_SUB   = 3'd1,
		CMD_MUL   = 3'd2,
		CMD_SCALE = 3'd3,
		CMD_NORM  = 3'd4
	} cmd_t;

	// Sideband carried through the length and division pipelines.
	typedef struct packed {
		cmd_t             cmd;
		logic [2:0][31:0] a;
		logic [2:0][31:0] r;
		logic             zf;
	} side_t;

	function automatic logic [31:0] mag32(input logic [31:0] c);
		return c[31] ? (~c + 32'd1) : c;
	endfunction

	function automatic logic [31:0] sat33(input logic [32:0] v);
		logic [31:0] res;
		if (v[32] != v[31]) begin
			res = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			res = v[31:0];
		end
		return res;
	endfunction

	// Round half up to FRAC_BITS fewer fraction bits, then saturate.
	function automatic logic [31:0] qround(input logic [63:0] p);
		logic [64:0]            t;
		logic [33-FRAC_BITS:0]  hi;
		logic [31:0]            res;
		t  = {p[63], p} + (65'd1 << (FRAC_BITS - 1));
		hi = t[64:FRAC_BITS+31];
		if ((&hi) || !(|hi)) begin
			res = t[FRAC_BITS+31:FRAC_BITS];
		end else begin
			res = t[64] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		return res;
	endfunction

endpackage

// File: design/vno_ifs.sv
// ----------------------------------------------------------------------------
// vno_ifs: item channels of the vector arithmetic unit
// Request channel with two vectors, a scalar and a command; response channel
// with the result vector, its length and the zero-length flag.
// ----------------------------------------------------------------------------
interface vno_req_if;
	logic              valid;
	logic              ready;
	logic [2:0]        cmd;
	logic signed [31:0] a_x;
	logic signed [31:0] a_y;
	logic signed [31:0] a_z;
	logic signed [31:0] b_x;
	logic signed [31:0] b_y;
	logic signed [31:0] b_z;
	logic signed [31:0] scale_factor;

	modport source (output valid, cmd, a_x, a_y, a_z, b_x, b_y, b_z, scale_factor,
		input ready);
	modport sink (input valid, cmd, a_x, a_y, a_z, b_x, b_y, b_z, scale_factor,
		output ready);
endinterface

interface vno_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] res_x;
	logic signed [31:0] res_y;
	logic signed [31:0] res_z;
	logic [31:0]        length;
	logic               zero_length;

	modport source (output valid, res_x, res_y, res_z, length, zero_length,
		input ready);
	modport sink (input valid, res_x, res_y, res_z, length, zero_length,
		output ready);
endinterface

// File: design/vno_sqrt.sv
// ----------------------------------------------------------------------------
// vno_sqrt: pipelined rounded square root
// One result bit per stage over a 64-bit radicand, then a rounding stage that
// saturates the length to 32 bits. A sideband record travels alongside.
// ----------------------------------------------------------------------------
module vno_sqrt (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld,
	input  logic [63:0]   sum,
	input  vno_pkg::side_t side,
	output logic          res_vld,
	output logic [31:0]   len,
	output vno_pkg::side_t res_side
);
	import vno_pkg::*;

	logic [63:0] n_s [SQ_STEPS];
	logic [63:0] r_s [SQ_STEPS];
	side_t       side_s [SQ_STEPS];
	logic        v_s [SQ_STEPS];

	logic [63:0] n_src [SQ_STEPS];
	logic [63:0] r_src [SQ_STEPS];
	logic [63:0] n_nxt [SQ_STEPS];
	logic [63:0] r_nxt [SQ_STEPS];

	logic [63:0] n_last;
	logic [63:0] r_last;
	logic [32:0] rnd;

	always_comb begin
		logic [63:0] one_w;
		logic [63:0] trial;
		n_src[0] = sum;
		r_src[0] = '0;
		for (int k = 1; k < SQ_STEPS; k++) begin
			n_src[k] = n_s[k-1];
			r_src[k] = r_s[k-1];
		end
		for (int k = 0; k < SQ_STEPS; k++) begin
			one_w = 64'd1 << (62 - 2 * k);
			trial = r_src[k] + one_w;
			if (n_src[k] >= trial) begin
				n_nxt[k] = n_src[k] - trial;
				r_nxt[k] = (r_src[k] >> 1) + one_w;
			end else begin
				n_nxt[k] = n_src[k];
				r_nxt[k] = r_src[k] >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SQ_STEPS; k++) v_s[k] <= 1'b0;
			res_vld <= 1'b0;
		end else if (en) begin
			v_s[0] <= vld;
			for (int k = 1; k < SQ_STEPS; k++) v_s[k] <= v_s[k-1];
			res_vld <= v_s[SQ_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side;
			for (int k = 1; k < SQ_STEPS; k++) side_s[k] <= side_s[k-1];
			for (int k = 0; k < SQ_STEPS; k++) begin
				n_s[k] <= n_nxt[k];
				r_s[k] <= r_nxt[k];
			end
		end
	end

	// The remainder left over is s - r*r; round up when it exceeds r.
	assign n_last = n_s[SQ_STEPS-1];
	assign r_last = r_s[SQ_STEPS-1];
	assign rnd    = r_last[32:0] + {32'd0, (n_last > r_last)};

	always_ff @(posedge clk) begin
		if (en) begin
			len      <= rnd[32] ? 32'hFFFF_FFFF : rnd[31:0];
			res_side <= side_s[SQ_STEPS-1];
		end
	end

endmodule

// File: design/vno_ndiv.sv
// ----------------------------------------------------------------------------
// vno_ndiv: pipelined normalizing divider
// Three restoring-division lanes, one quotient bit per stage, that divide
// each component of A by the length of A with rounding half away from zero.
// ----------------------------------------------------------------------------
module vno_ndiv (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld,
	input  logic [31:0]   len,
	input  vno_pkg::side_t side,
	output logic          res_vld,
	output vno_pkg::side_t res_side
);
	import vno_pkg::*;

	// Stage 0 prepares the dividends; stages 1..QW each settle one bit.
	logic [DW-1:0] rem_s [QW+1][3];
	logic [QW-1:0] q_s   [QW+1][3];
	logic [31:0]   len_s [QW+1];
	side_t         side_s [QW+1];
	logic          v_s [QW+1];

	logic [DW-1:0] rem_nxt [QW+1][3];
	logic [QW-1:0] q_nxt   [QW+1][3];

	side_t         side_fin;

	always_comb begin
		logic [DW-1:0] d;
		for (int l = 0; l < 3; l++) begin
			rem_nxt[0][l] = (DW'(mag32(side.a[l])) << FRAC_BITS) + DW'(len >> 1);
			q_nxt[0][l]   = '0;
		end
		for (int j = 1; j <= QW; j++) begin
			d = DW'(len_s[j-1]) << (QW - j);
			for (int l = 0; l < 3; l++) begin
				if (rem_s[j-1][l] >= d) begin
					rem_nxt[j][l] = rem_s[j-1][l] - d;
					q_nxt[j][l]   = q_s[j-1][l] | (QW'(1) << (QW - j));
				end else begin
					rem_nxt[j][l] = rem_s[j-1][l];
					q_nxt[j][l]   = q_s[j-1][l];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= QW; j++) v_s[j] <= 1'b0;
			res_vld <= 1'b0;
		end else if (en) begin
			v_s[0] <= vld;
			for (int j = 1; j <= QW; j++) v_s[j] <= v_s[j-1];
			res_vld <= v_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len_s[0]  <= len;
			side_s[0] <= side;
			for (int j = 1; j <= QW; j++) begin
				len_s[j]  <= len_s[j-1];
				side_s[j] <= side_s[j-1];
			end
			for (int j = 0; j <= QW; j++) begin
				for (int l = 0; l < 3; l++) begin
					rem_s[j][l] <= rem_nxt[j][l];
					q_s[j][l]   <= q_nxt[j][l];
				end
			end
		end
	end

	// Final stage: for a normalize, apply the sign or flag a zero-length vector.
	always_comb begin
		side_fin    = side_s[QW];
		side_fin.zf = 1'b0;
		if (side_s[QW].cmd == CMD_NORM) begin
			if (len_s[QW] == 32'd0) begin
				side_fin.r  = '0;
				side_fin.zf = 1'b1;
			end else begin
				for (int l = 0; l < 3; l++) begin
					side_fin.r[l] = side_s[QW].a[l][31] ?
						(~32'(q_s[QW][l]) + 32'd1) : 32'(q_s[QW][l]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_side <= side_fin;
		end
	end

endmodule

// File: design/vec3_arith_norm_unit_top.sv
// ----------------------------------------------------------------------------
// vec3_arith_norm_unit_top: Q16.16 three-vector arithmetic with length
// Add, subtract, componentwise multiply, scale and normalize, each result
// followed by its rounded Euclidean length.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on req (valid/ready) with a command, vectors A and B and a
// scalar. Each item yields exactly one item on rsp with the saturated result
// vector, its saturated length and the zero-length flag.
// The block is a single pipeline: two operand stages, a 33-stage square root
// for the length of A, a divider of FRAC_BITS+4 stages, two squaring stages
// and a second 33-stage square root for the result length. Every command
// takes this path; results are signed Q16.16 and lengths unsigned Q16.16.
// Throughput is one item per cycle while rsp does not stall; req.ready is
// high whenever the output register is empty or being read.
// When rsp stalls, the whole pipeline holds and req.ready drops; no item is
// lost or repeated. Reset clears all valid bits; req.ready is high while
// reset is held, as the output register is empty.
// ----------------------------------------------------------------------------
module vec3_arith_norm_unit_top (
	input  logic      clk,
	input  logic      arst_n,
	vno_req_if.sink   req,
	vno_rsp_if.source rsp
);
	import vno_pkg::*;

	logic en;

	logic [31:0] av [3];
	logic [31:0] bv [3];

	// Stage 1: products, squares of |A| and the sums.
	logic               v_s1;
	cmd_t               cmd_s1;
	logic [2:0][31:0]   a_s1;
	logic signed [63:0] prod_s1 [3];
	logic [63:0]        sq_s1 [3];
	logic [32:0]        as_s1 [3];

	// Stage 2: sum of squares and the finished simple results.
	logic        v_s2;
	logic [63:0] sum_s2;
	side_t       side_s2;
	side_t       side_nxt;

	logic        v_l;
	logic [31:0] len_a;
	side_t       side_l;

	logic        v_d;
	side_t       side_d;

	// Result squaring stages.
	logic        v_r1;
	logic [63:0] sq_r1 [3];
	side_t       side_r1;
	logic        v_r2;
	logic [63:0] sum_r2;
	side_t       side_r2;

	logic        v_o;
	logic [31:0] len_o;
	side_t       side_o;

	assign en        = !v_o || rsp.ready;
	assign req.ready = en;

	assign av[0] = req.a_x;
	assign av[1] = req.a_y;
	assign av[2] = req.a_z;
	assign bv[0] = req.b_x;
	assign bv[1] = req.b_y;
	assign bv[2] = req.b_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_r1 <= 1'b0;
			v_r2 <= 1'b0;
		end else if (en) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_r1 <= v_d;
			v_r2 <= v_r1;
		end
	end

	always_ff @(posedge clk) begin
		logic [31:0] m;
		logic [31:0] o1;
		if (en) begin
			cmd_s1 <= cmd_t'(req.cmd);
			for (int i = 0; i < 3; i++) begin
				o1 = (cmd_t'(req.cmd) == CMD_SCALE) ? req.scale_factor : bv[i];
				m  = mag32(av[i]);
				a_s1[i]    <= av[i];
				prod_s1[i] <= $signed(o1) * $signed(av[i]);
				sq_s1[i]   <= 64'(m) * 64'(m);
				if (cmd_t'(req.cmd) == CMD_SUB) begin
					as_s1[i] <= {bv[i][31], bv[i]} - {av[i][31], av[i]};
				end else begin
					as_s1[i] <= {bv[i][31], bv[i]} + {av[i][31], av[i]};
				end
			end
		end
	end

	always_comb begin
		side_nxt.cmd = cmd_s1;
		side_nxt.a   = a_s1;
		side_nxt.zf  = 1'b0;
		for (int i = 0; i < 3; i++) begin
			case (cmd_s1)
				CMD_ADD, CMD_SUB:   side_nxt.r[i] = sat33(as_s1[i]);
				CMD_MUL, CMD_SCALE: side_nxt.r[i] = qround(prod_s1[i]);
				default:            side_nxt.r[i] = 32'd0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2  <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			side_s2 <= side_nxt;
		end
	end

	vno_sqrt u_len_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld      (v_s2),
		.sum      (sum_s2),
		.side     (side_s2),
		.res_vld  (v_l),
		.len      (len_a),
		.res_side (side_l)
	);

	vno_ndiv u_ndiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld      (v_l),
		.len      (len_a),
		.side     (side_l),
		.res_vld  (v_d),
		.res_side (side_d)
	);

	always_ff @(posedge clk) begin
		logic [31:0] m;
		if (en) begin
			side_r1 <= side_d;
			for (int i = 0; i < 3; i++) begin
				m = mag32(side_d.r[i]);
				sq_r1[i] <= 64'(m) * 64'(m);
			end
			sum_r2  <= sq_r1[0] + sq_r1[1] + sq_r1[2];
			side_r2 <= side_r1;
		end
	end

	vno_sqrt u_len_r (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld      (v_r2),
		.sum      (sum_r2),
		.side     (side_r2),
		.res_vld  (v_o),
		.len      (len_o),
		.res_side (side_o)
	);

	assign rsp.valid       = v_o;
	assign rsp.res_x       = side_o.r[0];
	assign rsp.res_y       = side_o.r[1];
	assign rsp.res_z       = side_o.r[2];
	assign rsp.length      = len_o;
	assign rsp.zero_length = side_o.zf;

endmodule

// File: verif/tb_vec3_arith_norm_unit_top.sv
// ----------------------------------------------------------------------------
// tb_vec3_arith_norm_unit_top: self-checking bench of the vector arithmetic unit
// Drives directed corner vectors and random items of every command, predicts
// each result with an exact fixed-point model and checks results in order while
// both channels idle at random, apart from a final quiet phase.
// ----------------------------------------------------------------------------
module tb_vec3_arith_norm_unit_top;
	timeunit 1ns;
	timeprecision 1ps;
	import vno_pkg::*;

	localparam int LATENCY   = FRAC_BITS + 74;
	localparam int MAX_CYCLE = 200000;

	typedef struct {
		logic [2:0]         cmd;
		logic signed [31:0] a [3];
		logic signed [31:0] b [3];
		logic signed [31:0] sf;
	} vec_op_t;

	typedef struct {
		logic signed [31:0] r [3];
		logic [31:0]        len;
		logic               zf;
	} vec_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic quiet = 1'b0;
	logic hold = 1'b0;
	int   cycle = 0;
	int   errors = 0;
	int   n_sent = 0;
	int   n_checked = 0;
	int   n_zero = 0;
	int   req_gap = 0;
	int   rsp_gap = 0;

	vec_op_t  op_queue [$];
	vec_res_t expected_results [$];

	vno_req_if req ();
	vno_rsp_if rsp ();

	vec3_arith_norm_unit_top u_top (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source)
	);

	always #10 clk = ~clk;

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// Round half up via an arithmetic shift, which is floor for negatives.
	function automatic longint fix_mul(longint x, longint y);
		logic signed [65:0] p;
		p = x * y + (66'sd1 <<< (FRAC_BITS - 1));
		return clamp32(longint'(p >>> FRAC_BITS));
	endfunction

	function automatic logic [31:0] round_len(longint x, longint y, longint z);
		logic [65:0] s;
		logic [65:0] r;
		logic [65:0] bitv;
		logic [65:0] n;
		s = 66'(x * x) + 66'(y * y) + 66'(z * z);
		n = s;
		r = 0;
		bitv = 66'd1 << 64;
		while (bitv > n) begin
			bitv = bitv >> 2;
		end
		while (bitv != 0) begin
			if (n >= r + bitv) begin
				n = n - (r + bitv);
				r = (r >> 1) + bitv;
			end else begin
				r = r >> 1;
			end
			bitv = bitv >> 2;
		end
		if (s - r * r > r) begin
			r = r + 1;
		end
		return (r > 66'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
	endfunction

	function automatic vec_res_t predict_vec(vec_op_t op);
		vec_res_t res;
		longint   c [3];
		logic [31:0] l;
		logic [80:0] q;
		longint   v;
		for (int i = 0; i < 3; i++) begin
			c[i] = 0;
		end
		res.zf = 1'b0;
		case (op.cmd)
			CMD_ADD: begin
				for (int i = 0; i < 3; i++) c[i] = clamp32(longint'(op.b[i]) + op.a[i]);
			end
			CMD_SUB: begin
				for (int i = 0; i < 3; i++) c[i] = clamp32(longint'(op.b[i]) - op.a[i]);
			end
			CMD_MUL: begin
				for (int i = 0; i < 3; i++) c[i] = fix_mul(op.b[i], op.a[i]);
			end
			CMD_SCALE: begin
				for (int i = 0; i < 3; i++) c[i] = fix_mul(op.sf, op.a[i]);
			end
			CMD_NORM: begin
				l = round_len(op.a[0], op.a[1], op.a[2]);
				if (l == 0) begin
					res.zf = 1'b1;
				end else begin
					for (int i = 0; i < 3; i++) begin
						v = (op.a[i] < 0) ? -longint'(op.a[i]) : longint'(op.a[i]);
						q = ((81'(v) << FRAC_BITS) + (l >> 1)) / l;
						v = (q > 81'h1_0000_0000) ? 64'sh1_0000_0000 : longint'(q);
						c[i] = clamp32(op.a[i] < 0 ? -v : v);
					end
				end
			end
			default: ;
		endcase
		for (int i = 0; i < 3; i++) begin
			res.r[i] = c[i][31:0];
		end
		res.len = round_len(c[0], c[1], c[2]);
		return res;
	endfunction

	function automatic logic signed [31:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return 32'sh7FFF_FFFF - $urandom_range(0, 2);
			1: return 32'sh8000_0000 + $urandom_range(0, 2);
			2: return $signed(32'($urandom_range(0, 131072)) - 32'd65536);
			3: return $signed(32'($urandom_range(0, 2 ** 22)) - 32'd2097152);
			default: return $urandom;
		endcase
	endfunction

	task automatic add_op(logic [2:0] cmd, logic signed [31:0] a, logic signed [31:0] b,
		logic signed [31:0] sf);
		vec_op_t op;
		op.cmd = cmd;
		for (int i = 0; i < 3; i++) begin
			op.a[i] = a;
			op.b[i] = b;
		end
		op.sf = sf;
		op_queue.push_back(op);
	endtask

	// Driver: hands out queued items, idling in short random bursts.
	always @(posedge clk or negedge arst_n) begin
		vec_op_t op;
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.cmd <= '0;
			req.a_x <= '0; req.a_y <= '0; req.a_z <= '0;
			req.b_x <= '0; req.b_y <= '0; req.b_z <= '0;
			req.scale_factor <= '0;
		end else if (!req.valid || req.ready) begin
			if (req.valid) begin
				op.cmd = req.cmd;
				op.a[0] = req.a_x; op.a[1] = req.a_y; op.a[2] = req.a_z;
				op.b[0] = req.b_x; op.b[1] = req.b_y; op.b[2] = req.b_z;
				op.sf = req.scale_factor;
				expected_results.push_back(predict_vec(op));
				n_sent++;
			end
			if (req_gap > 0) begin
				req_gap--;
				req.valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				req_gap = $urandom_range(0, 2);
				req.valid <= 1'b0;
			end else if (op_queue.size() > 0 && !hold) begin
				op = op_queue.pop_front();
				req.valid <= 1'b1;
				req.cmd <= op.cmd;
				req.a_x <= op.a[0]; req.a_y <= op.a[1]; req.a_z <= op.a[2];
				req.b_x <= op.b[0]; req.b_y <= op.b[1]; req.b_z <= op.b[2];
				req.scale_factor <= op.sf;
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// Monitor: checks each result against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		vec_res_t exp_res;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			cycle++;
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result x=%h", rsp.res_x);
					errors++;
				end else begin
					exp_res = expected_results.pop_front();
					n_checked++;
					if (exp_res.zf) n_zero++;
					if (rsp.res_x !== exp_res.r[0]) begin
						$error("res_x expected %h actual %h", exp_res.r[0], rsp.res_x);
						errors++;
					end
					if (rsp.res_y !== exp_res.r[1]) begin
						$error("res_y expected %h actual %h", exp_res.r[1], rsp.res_y);
						errors++;
					end
					if (rsp.res_z !== exp_res.r[2]) begin
						$error("res_z expected %h actual %h", exp_res.r[2], rsp.res_z);
						errors++;
					end
					if (rsp.length !== exp_res.len) begin
						$error("length expected %h actual %h", exp_res.len, rsp.length);
						errors++;
					end
					if (rsp.zero_length !== exp_res.zf) begin
						$error("zero_length expected %b actual %b", exp_res.zf,
							rsp.zero_length);
						errors++;
					end
				end
			end
			if (rsp_gap > 0) begin
				rsp_gap--;
				rsp.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				rsp_gap = $urandom_range(0, 2);
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	initial begin
		vec_op_t op;
		int      n_rand;
		// Directed: extremes of each field under every command, plus zero
		// vectors for normalize and the meaningless command codes.
		add_op(CMD_ADD, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
		add_op(CMD_ADD, 32'sh8000_0000, 32'sh8000_0000, 0);
		add_op(CMD_SUB, 32'sh8000_0000, 32'sh7FFF_FFFF, 0);
		add_op(CMD_SUB, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
		add_op(CMD_MUL, 32'sh8000_0000, 32'sh8000_0000, 0);
		add_op(CMD_MUL, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
		add_op(CMD_MUL, 32'sh0000_8000, 32'sh0000_0001, 0);
		add_op(CMD_MUL, 32'sh0000_8000, -32'sh0000_0001, 0);
		add_op(CMD_SCALE, 32'sh0001_0000, 0, 32'sh8000_0000);
		add_op(CMD_SCALE, 32'sh8000_0000, 0, 32'sh7FFF_FFFF);
		add_op(CMD_NORM, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		add_op(CMD_NORM, 32'sh8000_0000, 0, 0);
		add_op(CMD_NORM, 32'sh7FFF_FFFF, 0, 0);
		add_op(CMD_NORM, 1, 0, 0);
		add_op(CMD_NORM, -1, 0, 0);
		add_op(3'd5, 32'sh1234_5678, -1, -1);
		add_op(3'd6, -1, -1, -1);
		add_op(3'd7, 32'sh7FFF_FFFF, 32'sh8000_0000, 5);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		for (n_rand = 0; n_rand < 1200; n_rand++) begin
			op.cmd = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
				: 3'($urandom_range(0, 4));
			for (int i = 0; i < 3; i++) begin
				op.a[i] = ($urandom_range(0, 19) == 0) ? 32'sd0 : rand_comp();
				op.b[i] = rand_comp();
			end
			op.sf = rand_comp();
			op_queue.push_back(op);
			if (n_rand == 400) begin
				wait (op_queue.size() == 0);
				hold = 1'b1;
				wait (!req.valid && expected_results.size() == 0);
				hold = 1'b0;
			end
			if (n_rand == 1000) begin
				wait (op_queue.size() == 0);
				quiet = 1'b1;
			end
		end
		wait (op_queue.size() == 0 && !req.valid && expected_results.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		$display("Checked %0d results from %0d items over all five commands and", n_checked,
			n_sent);
		$display("the unused codes; %0d zero-vector normalizations.", n_zero);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		wait (cycle >= MAX_CYCLE);
		$display("Timeout after %0d cycles", cycle);
		$display("Test completed with failures");
		$finish;
	end

endmodule
